// ----- sv/fqks_pkg.sv -----
// ----------------------------------------------------------------------------
// fqks_pkg
// Shared types, constants and helpers for the record queue with key search.
// ----------------------------------------------------------------------------
package fqks_pkg;

  // Record queue geometry.
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Field widths of the transfers.
  localparam int unsigned OP_W  = 2;
  localparam int unsigned NUM_W = 16;
  localparam int unsigned CAR_W = 32;
  localparam int unsigned ST_W  = 2;
  localparam int unsigned OCC_W = 5;

  // Command queue between the front and the back.
  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Opcodes of an input item.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Status codes of a result.
  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Command class decided by the front, one-hot.
  typedef enum logic [3:0] {
    K_PUSH   = 4'b0001,
    K_POP    = 4'b0010,
    K_SEARCH = 4'b0100,
    K_NOP    = 4'b1000
  } kind_e;

  // Input item.
  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [NUM_W-1:0] flight_number;
    logic [CAR_W-1:0] carrier_code;
  } item_t;

  // Result item.
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [NUM_W-1:0] popped_number;
    logic [CAR_W-1:0] popped_carrier;
    logic [OCC_W-1:0] occupancy;
  } result_t;

  // Classified command held in the command queue.
  typedef struct packed {
    kind_e            kind;
    logic [NUM_W-1:0] key;
    logic [CAR_W-1:0] carrier;
  } cmd_t;

  // Ring index advance with wrap at the queue depth.
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == IDX_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + 1'b1;
    end
    return r;
  endfunction

endpackage

// ----- sv/fqks_front.sv -----
// ----------------------------------------------------------------------------
// fqks_front
// Accepts input items, decodes the opcode into a command class and holds the
// classified commands in a short queue until the back takes them.
// ----------------------------------------------------------------------------
module fqks_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  fqks_pkg::item_t  item_i,
  output logic             cmd_valid_o,
  output fqks_pkg::cmd_t   cmd_o,
  input  logic             cmd_pop_i
);

  fqks_pkg::cmd_t                        q_mem [fqks_pkg::CMDQ_DEPTH];
  logic [fqks_pkg::CMDQ_PTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [fqks_pkg::CMDQ_PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [fqks_pkg::CMDQ_CNT_W-1:0]       cnt_q, cnt_d;
  logic                                  full;
  logic                                  push;
  logic                                  pop;
  fqks_pkg::kind_e                       kind;
  fqks_pkg::cmd_t                        cmd_in;

  // An item transfers when start is high and the queue has room.
  assign full   = (cnt_q == fqks_pkg::CMDQ_CNT_W'(fqks_pkg::CMDQ_DEPTH));
  assign busy_o = full;
  assign push   = start_i & ~full;
  assign pop    = cmd_pop_i & (cnt_q != '0);

  // Opcode decode into a one-hot command class.
  always_comb begin
    unique case (fqks_pkg::op_e'(item_i.opcode))
      fqks_pkg::OP_PUSH:   kind = fqks_pkg::K_PUSH;
      fqks_pkg::OP_POP:    kind = fqks_pkg::K_POP;
      fqks_pkg::OP_SEARCH: kind = fqks_pkg::K_SEARCH;
      fqks_pkg::OP_NONE:   kind = fqks_pkg::K_NOP;
      default:             kind = fqks_pkg::K_NOP;
    endcase
  end

  assign cmd_in = '{kind: kind, key: item_i.flight_number, carrier: item_i.carrier_code};

  // Queue pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      if (wr_ptr_q == fqks_pkg::CMDQ_PTR_W'(fqks_pkg::CMDQ_DEPTH - 1)) begin
        wr_ptr_d = '0;
      end else begin
        wr_ptr_d = wr_ptr_q + 1'b1;
      end
    end
    if (pop) begin
      if (rd_ptr_q == fqks_pkg::CMDQ_PTR_W'(fqks_pkg::CMDQ_DEPTH - 1)) begin
        rd_ptr_d = '0;
      end else begin
        rd_ptr_d = rd_ptr_q + 1'b1;
      end
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Command storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];

endmodule

// ----- sv/fqks_back.sv -----
// ----------------------------------------------------------------------------
// fqks_back
// Executes classified commands against the record memory: push writes the
// tail slot, pop reads the head slot, search walks the held records one per
// cycle from the head. Drives the registered result strobe.
// ----------------------------------------------------------------------------
module fqks_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  fqks_pkg::cmd_t     cmd_i,
  output logic               cmd_pop_o,
  output logic               done_o,
  output fqks_pkg::result_t  result_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_POPRD = 3'b010,
    S_SCAN  = 3'b100
  } state_e;

  // Record memory.
  logic [fqks_pkg::NUM_W-1:0] number_mem  [fqks_pkg::QUEUE_DEPTH];
  logic [fqks_pkg::CAR_W-1:0] carrier_mem [fqks_pkg::QUEUE_DEPTH];
  logic [fqks_pkg::NUM_W-1:0] rd_num_q;
  logic [fqks_pkg::CAR_W-1:0] rd_car_q;
  logic [fqks_pkg::IDX_W-1:0] rd_addr;
  logic                       wr_en;

  state_e                     state_q, state_d;
  logic [fqks_pkg::IDX_W-1:0] head_q, head_d;
  logic [fqks_pkg::IDX_W-1:0] tail_q, tail_d;
  logic [fqks_pkg::CNT_W-1:0] count_q, count_d;
  logic [fqks_pkg::IDX_W-1:0] scan_addr_q, scan_addr_d;
  logic [fqks_pkg::CNT_W-1:0] remain_q, remain_d;
  logic [fqks_pkg::NUM_W-1:0] key_q, key_d;
  logic                       done_q, done_d;
  fqks_pkg::result_t          res_q, res_d;

  fqks_pkg::status_e          st;
  logic [fqks_pkg::NUM_W-1:0] pnum;
  logic [fqks_pkg::CAR_W-1:0] pcar;
  logic                       is_full;
  logic                       is_empty;

  assign is_full  = (count_q == fqks_pkg::CNT_W'(fqks_pkg::QUEUE_DEPTH));
  assign is_empty = (count_q == '0);

  // Command execution.
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    scan_addr_d = scan_addr_q;
    remain_d    = remain_q;
    key_d       = key_q;
    rd_addr     = head_q;
    wr_en       = 1'b0;
    cmd_pop_o   = 1'b0;
    done_d      = 1'b0;
    st          = fqks_pkg::ST_OK;
    pnum        = '0;
    pcar        = '0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.kind)
            fqks_pkg::K_PUSH: begin
              done_d = 1'b1;
              if (is_full) begin
                st = fqks_pkg::ST_FULL;
              end else begin
                wr_en   = 1'b1;
                tail_d  = fqks_pkg::next_idx(tail_q);
                count_d = count_q + 1'b1;
              end
            end
            fqks_pkg::K_POP: begin
              if (is_empty) begin
                done_d = 1'b1;
                st     = fqks_pkg::ST_EMPTY;
              end else begin
                state_d = S_POPRD;
              end
            end
            fqks_pkg::K_SEARCH: begin
              if (is_empty) begin
                done_d = 1'b1;
                st     = fqks_pkg::ST_EMPTY;
              end else begin
                scan_addr_d = fqks_pkg::next_idx(head_q);
                remain_d    = count_q;
                key_d       = cmd_i.key;
                state_d     = S_SCAN;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      // Head record is in the read register now.
      S_POPRD: begin
        done_d  = 1'b1;
        pnum    = rd_num_q;
        pcar    = rd_car_q;
        head_d  = fqks_pkg::next_idx(head_q);
        count_d = count_q - 1'b1;
        state_d = S_IDLE;
      end

      // Compare the record read last cycle while fetching the next one.
      S_SCAN: begin
        rd_addr = scan_addr_q;
        if (rd_num_q == key_q) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (remain_q == fqks_pkg::CNT_W'(1)) begin
          done_d  = 1'b1;
          st      = fqks_pkg::ST_NOTFOUND;
          state_d = S_IDLE;
        end else begin
          scan_addr_d = fqks_pkg::next_idx(scan_addr_q);
          remain_d    = remain_q - 1'b1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Result carries the occupancy after the operation.
    res_d = res_q;
    if (done_d) begin
      res_d = '{status:         st,
                popped_number:  pnum,
                popped_carrier: pcar,
                occupancy:      fqks_pkg::OCC_W'(count_d)};
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      scan_addr_q <= '0;
      remain_q    <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      scan_addr_q <= scan_addr_d;
      remain_q    <= remain_d;
      done_q      <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    res_q <= res_d;
  end

  // Record memory: one write port at the tail, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      number_mem[tail_q]  <= cmd_i.key;
      carrier_mem[tail_q] <= cmd_i.carrier;
    end
    rd_num_q <= number_mem[rd_addr];
    rd_car_q <= carrier_mem[rd_addr];
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ----- sv/fifo_queue_with_key_search_top.sv -----
// From transfer to result strobe, a command passes the command queue and the result
// register; a pop also passes the record read register and S_POPRD, and a search walks
// the held records in S_SCAN, one record memory read per cycle, from the head until a
// match or the last record. A two-entry command queue lets start be taken meanwhile.
// Results are strobed for one cycle and the receiver cannot stall them.
// Reset is asynchronous, active low, and empties both the record queue and the command queue.
// ----------------------------------------------------------------------------
// fifo_queue_with_key_search_top
// Bounded record queue with push, pop and search by flight number.
// ----------------------------------------------------------------------------
module fifo_queue_with_key_search_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  fqks_pkg::item_t    item_i,
  output logic               done_o,
  output fqks_pkg::result_t  result_o
);

  logic           cmd_valid;
  logic           cmd_pop;
  fqks_pkg::cmd_t cmd;

  // Front: item transfer and opcode decode.
  fqks_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Back: record memory and execution.
  fqks_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .done_o      (done_o),
    .result_o    (result_o)
  );

endmodule

// ----- sv/fqks_checker.sv -----
// ----------------------------------------------------------------------------
// fqks_checker
// Port-level checks of the record queue results over time.
// ----------------------------------------------------------------------------
module fqks_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input fqks_pkg::result_t  result_o
);

  logic [fqks_pkg::OCC_W-1:0] last_occ_q;
  logic                       occ_step_ok;
  logic                       in_seen;

  assign in_seen = start & ~busy;

  // Occupancy seen in the previous result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_occ_q <= '0;
    end else if (done_o) begin
      last_occ_q <= result_o.occupancy;
    end
  end

  assign occ_step_ok = (result_o.occupancy == last_occ_q) ||
                       (result_o.occupancy == last_occ_q + 1'b1) ||
                       (result_o.occupancy == last_occ_q - 1'b1);

  // Occupancy moves by at most one record per result.
  a_occ_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> occ_step_ok)
    else $error("occupancy moved by more than one record");

  // A failed operation returns no record.
  a_fail_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status != fqks_pkg::ST_OK) |->
      (result_o.popped_number == '0 && result_o.popped_carrier == '0))
    else $error("record returned with a failure status");

  // Full is reported only at full occupancy, empty only at zero.
  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |->
      ((result_o.status != fqks_pkg::ST_FULL ||
        result_o.occupancy == fqks_pkg::OCC_W'(fqks_pkg::QUEUE_DEPTH)) &&
       (result_o.status != fqks_pkg::ST_EMPTY || result_o.occupancy == '0)))
    else $error("full or empty status disagrees with occupancy");

  // Right after reset, no result strobe appears while no item is transferring.
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$past(rst_ni) && !in_seen) |-> !done_o)
    else $error("result strobe right after reset");

endmodule

bind fifo_queue_with_key_search_top fqks_checker u_fqks_checker (.*);
